>>> rtl/core/assert_macros.svh
// Assertion macros shared by the jitter generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/hjg_pkg.sv
// Package: types, constants and arithmetic helpers of the jitter generator.
package hjg_pkg;

    localparam int INDEX_BITS    = 32;
    localparam int FRACTION_BITS = 24;
    localparam int OUT_W         = 24;
    localparam int FRAME_W       = 31;
    localparam int LAST_W        = 32;
    localparam int MODE_W        = 2;

    localparam logic [MODE_W-1:0] MODE_TEMPORAL = 2'd2;

    function automatic int trit_count(input int bits);
        logic [63:0] p;
        int n;
        p = 64'd1;
        n = 0;
        for (int k = 0; k < 64; k++) begin
            if (p <= ((64'd1 << bits) - 64'd1)) begin
                p = p * 64'd3;
                n++;
            end
        end
        return n;
    endfunction

    localparam int TRITS     = trit_count(INDEX_BITS);
    localparam int TRIT_IDX_W = $clog2(TRITS);

    localparam int DIV3_IN_W  = FRACTION_BITS + 2;
    localparam int DIV3_SHIFT = FRACTION_BITS + 4;
    localparam int DIV3_K_W   = DIV3_SHIFT - 1;
    localparam logic [DIV3_K_W-1:0] DIV3_K =
        DIV3_K_W'((((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3));

    typedef logic signed [OUT_W-1:0] jitter_t;
    typedef logic [1:0] trit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_STORE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic store_y;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic advance;
        logic last_digit;
    } dp_status_t;

    function automatic logic [FRACTION_BITS-1:0] div3(input logic [DIV3_IN_W-1:0] x);
        logic [DIV3_IN_W+DIV3_K_W-1:0] prod;
        prod = DIV3_IN_W'(x) * DIV3_K;
        return FRACTION_BITS'(prod >> DIV3_SHIFT);
    endfunction

    function automatic logic [FRACTION_BITS-1:0] rev_fixed(input logic [INDEX_BITS-1:0] idx);
        logic [INDEX_BITS+FRACTION_BITS-1:0] w;
        w = '0;
        for (int k = 0; k < INDEX_BITS; k++) begin
            w[INDEX_BITS+FRACTION_BITS-1-k] = idx[k];
        end
        return w[INDEX_BITS+FRACTION_BITS-1:INDEX_BITS];
    endfunction

    function automatic jitter_t to_jitter(input logic [FRACTION_BITS-1:0] r);
        logic [FRACTION_BITS-1:0] c;
        c = r;
        c[FRACTION_BITS-1] = ~r[FRACTION_BITS-1];
        return OUT_W'(signed'(c));
    endfunction

endpackage

>>> rtl/core/hjg_datapath.sv
// Datapath: mode register, sample index in binary and base 3, digit loop, jitter state.
`include "assert_macros.svh"

module hjg_datapath
    import hjg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [MODE_W-1:0]  cfg_wr_data,
    input  logic [FRAME_W-1:0] s_frame_number,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output jitter_t            m_jitter_x,
    output jitter_t            m_jitter_y,
    output jitter_t            m_previous_x,
    output jitter_t            m_previous_y
);

    logic [MODE_W-1:0]        mode_reg;
    logic [LAST_W-1:0]        last_frame_reg;
    logic [INDEX_BITS-1:0]    index_reg;
    logic [INDEX_BITS-1:0]    index_next;
    trit_t                    trits_reg [TRITS];
    trit_t                    trits_next [TRITS];
    logic [TRIT_IDX_W-1:0]    cnt_reg;
    logic [FRACTION_BITS-1:0] acc_reg;
    jitter_t                  cur_x_reg;
    jitter_t                  cur_y_reg;
    jitter_t                  prev_x_reg;
    jitter_t                  prev_y_reg;
    jitter_t                  out_x_reg;
    jitter_t                  out_y_reg;
    jitter_t                  out_px_reg;
    jitter_t                  out_py_reg;
    logic                     temporal;
    logic                     carry;

    assign temporal          = (mode_reg == MODE_TEMPORAL);
    assign status.advance    = temporal && (last_frame_reg != {1'b0, s_frame_number});
    assign status.last_digit = (cnt_reg == '0);
    assign index_next        = index_reg + INDEX_BITS'(1);

    always_comb begin
        carry = 1'b1;
        for (int k = 0; k < TRITS; k++) begin
            if (index_next == '0) begin
                trits_next[k] = 2'd0;
            end else if (carry && (trits_reg[k] == 2'd2)) begin
                trits_next[k] = 2'd0;
            end else begin
                trits_next[k] = trits_reg[k] + {1'b0, carry};
                carry = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= '0;
            last_frame_reg <= '1;
            index_reg      <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            for (int k = 0; k < TRITS; k++) begin
                trits_reg[k] <= 2'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.accept) begin
                if (!temporal) begin
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    cur_x_reg  <= '0;
                    cur_y_reg  <= '0;
                end else if (status.advance) begin
                    last_frame_reg <= {1'b0, s_frame_number};
                    prev_x_reg     <= cur_x_reg;
                    prev_y_reg     <= cur_y_reg;
                    index_reg      <= index_next;
                    cur_x_reg      <= to_jitter(rev_fixed(index_next));
                    trits_reg      <= trits_next;
                end
            end
            if (cmd.store_y) begin
                cur_y_reg <= to_jitter(acc_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cnt_reg <= TRIT_IDX_W'(TRITS - 1);
            acc_reg <= '0;
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg - TRIT_IDX_W'(1);
            acc_reg <= div3({trits_reg[cnt_reg], acc_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_x_reg  <= cur_x_reg;
            out_y_reg  <= cur_y_reg;
            out_px_reg <= prev_x_reg;
            out_py_reg <= prev_y_reg;
        end
    end

    assign m_jitter_x   = out_x_reg;
    assign m_jitter_y   = out_y_reg;
    assign m_previous_x = out_px_reg;
    assign m_previous_y = out_py_reg;

    `ASSERT_NEXT(a_cfg_write, aclk, aresetn, cfg_wr_en, mode_reg == $past(cfg_wr_data))
    `ASSERT_NEXT(a_frame_latch, aclk, aresetn, cmd.accept && status.advance,
        last_frame_reg == LAST_W'($past(s_frame_number)))

endmodule

>>> rtl/core/hjg_controller.sv
// Controller: sequences acceptance, the base-3 digit loop and the output register.
`include "assert_macros.svh"

module hjg_controller
    import hjg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = status.advance ? ST_DIGITS : ST_OUTPUT;
                end
            end
            ST_DIGITS: begin
                if (status.last_digit) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_DIGITS: begin
                cmd.step = 1'b1;
            end
            ST_STORE: begin
                cmd.store_y = 1'b1;
            end
            ST_OUTPUT: begin
                cmd.load_out = !m_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_SAME(a_valid_from_output, aclk, aresetn, $rose(m_valid_reg),
        $past(state_reg) == ST_OUTPUT)
    `ASSERT_NEXT(a_advance_runs_digits, aclk, aresetn, accept && status.advance,
        state_reg == ST_DIGITS)
    `ASSERT_NEXT(a_last_digit_stores, aclk, aresetn,
        (state_reg == ST_DIGITS) && status.last_digit, state_reg == ST_STORE)

endmodule

>>> rtl/core/halton_jitter_generator_core.sv
// Top level: Halton (2,3) subpixel jitter generator, controller plus datapath.
// A request that advances the sequence (temporal mode, new frame number) goes
// from acceptance to a loaded result in these steps: acceptance, which forms the
// base-2 jitter by bit reversal; the base-3 digit loop over 21 digits (one digit
// and one multiply-by-reciprocal divide by three per cycle); storing the y jitter;
// and loading the output register. Any other request skips to the load.
// A new request is taken once the previous result sits in the output register,
// even while that result still waits to be read.
module halton_jitter_generator_core
    import hjg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [MODE_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FRAME_W-1:0] s_frame_number,
    output logic               m_valid,
    input  logic               m_ready,
    output jitter_t            m_jitter_x,
    output jitter_t            m_jitter_y,
    output jitter_t            m_previous_x,
    output jitter_t            m_previous_y
);

    dp_cmd_t    cmd;
    dp_status_t status;

    hjg_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hjg_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_frame_number (s_frame_number),
        .cmd            (cmd),
        .status         (status),
        .m_jitter_x     (m_jitter_x),
        .m_jitter_y     (m_jitter_y),
        .m_previous_x   (m_previous_x),
        .m_previous_y   (m_previous_y)
    );

endmodule

>>> test/testbench.sv
// Self-checking testbench for the Halton (2,3) subpixel jitter generator core.
module testbench;
    import hjg_pkg::*;

    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPATIAL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
    localparam logic [FRAME_W-1:0] FRAME_MAX    = '1;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 62;

    typedef struct {
        jitter_t x;
        jitter_t y;
        jitter_t px;
        jitter_t py;
    } jitter_set_t;

    class halton_jitter_tracker;
        logic [MODE_W-1:0]     mode;
        logic [LAST_W-1:0]     last_frame;
        logic [INDEX_BITS-1:0] sample_index;
        jitter_t               cur_x;
        jitter_t               cur_y;
        jitter_t               prev_x;
        jitter_t               prev_y;
        jitter_set_t           pending_jitter[$];
        int                    errors;

        function new();
            mode         = MODE_OFF;
            last_frame   = '1;
            sample_index = '0;
            cur_x        = '0;
            cur_y        = '0;
            prev_x       = '0;
            prev_y       = '0;
            errors       = 0;
        endfunction

        function jitter_t radical_jitter(logic [INDEX_BITS-1:0] idx, int unsigned base);
            int unsigned       digit_buf[32];
            int                n;
            longint unsigned   rest;
            longint unsigned   acc;
            logic [63:0]       centered;
            n    = 0;
            rest = 64'(idx);
            acc  = 0;
            while (rest > 0 && n < 32) begin
                digit_buf[n] = 32'(rest % base);
                rest = rest / base;
                n++;
            end
            while (n > 0) begin
                n--;
                acc = ((64'(digit_buf[n]) << FRACTION_BITS) + acc) / base;
            end
            centered = acc - (64'd1 << (FRACTION_BITS - 1));
            return centered[OUT_W-1:0];
        endfunction

        function void take_request(logic [FRAME_W-1:0] frame);
            if (mode != MODE_TEMPORAL) begin
                prev_x = cur_x;
                prev_y = cur_y;
                cur_x  = '0;
                cur_y  = '0;
            end else if (LAST_W'(frame) != last_frame) begin
                last_frame   = LAST_W'(frame);
                prev_x       = cur_x;
                prev_y       = cur_y;
                sample_index = sample_index + 1'b1;
                cur_x        = radical_jitter(sample_index, 2);
                cur_y        = radical_jitter(sample_index, 3);
            end
            pending_jitter.push_back('{cur_x, cur_y, prev_x, prev_y});
        endfunction

        function void compare_field(string field, jitter_t want, jitter_t got);
            if (want !== got) begin
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void match_result(jitter_t x, jitter_t y, jitter_t px, jitter_t py);
            jitter_set_t want;
            if (pending_jitter.size() == 0) begin
                $display("%0t: result with no request pending, jitter_x %0d jitter_y %0d",
                         $time, x, y);
                errors++;
                return;
            end
            want = pending_jitter.pop_front();
            compare_field("jitter_x", want.x, x);
            compare_field("jitter_y", want.y, y);
            compare_field("previous_x", want.px, px);
            compare_field("previous_y", want.py, py);
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [MODE_W-1:0]  cfg_wr_data = MODE_OFF;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [FRAME_W-1:0] s_frame_number = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    jitter_t            m_jitter_x;
    jitter_t            m_jitter_y;
    jitter_t            m_previous_x;
    jitter_t            m_previous_y;

    halton_jitter_tracker jitter_track = new();
    int tx_burst = 0;
    int rx_hold = 0;
    int rx_burst = 0;
    int stall_cycles = 0;

    halton_jitter_generator_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_number (s_frame_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_jitter_x     (m_jitter_x),
        .m_jitter_y     (m_jitter_y),
        .m_previous_x   (m_previous_x),
        .m_previous_y   (m_previous_y)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [FRAME_W-1:0] frame);
        int gap;
        gap = 0;
        if (tx_burst > 0) begin
            tx_burst--;
        end else if ($urandom_range(0, 29) == 0) begin
            tx_burst = $urandom_range(15, 60);
        end else begin
            gap = idle_length();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        // hold valid until accepted
        s_valid <= 1'b1;
        s_frame_number <= frame;
        do @(posedge aclk); while (!s_ready);
        jitter_track.take_request(frame);
    endtask

    task automatic drain_requests();
        s_valid <= 1'b0;
        do @(posedge aclk); while (jitter_track.pending_jitter.size() > 0);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        drain_requests();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        jitter_track.mode = mode;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (rx_burst > 0) begin
                rx_burst <= rx_burst - 1;
            end else if ($urandom_range(0, 39) == 0) begin
                rx_burst <= $urandom_range(20, 80);
            end else begin
                rx_hold <= idle_length();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            jitter_track.match_result(m_jitter_x, m_jitter_y, m_previous_x, m_previous_y);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("halton_jitter_generator_core: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [FRAME_W-1:0] frame;
        int pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(FRAME_MAX);
        send_request('0);

        write_mode(MODE_TEMPORAL);
        send_request('0);
        send_request('0);
        send_request('0);
        send_request(31'd1);
        send_request(FRAME_MAX);
        send_request(FRAME_MAX);
        send_request(31'h2AAA_AAAA);
        send_request(31'h5555_5555);
        send_request(31'd2);
        send_request(31'd3);

        write_mode(MODE_RESERVED);
        send_request(31'd3);
        send_request(31'd4);

        write_mode(MODE_SPATIAL);
        send_request(31'd4);

        // frame 4 differs from the last advance (frame 3): advances, previous is the cleared jitter
        write_mode(MODE_TEMPORAL);
        send_request(31'd4);
        send_request(31'd4);
        send_request(31'd5);

        write_mode(MODE_OFF);
        send_request(31'd5);

        frame = FRAME_W'($urandom());
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase % 3 == 1) begin
                write_mode(MODE_W'($urandom_range(0, 3)));
            end else begin
                write_mode(MODE_TEMPORAL);
            end
            for (int item = 0; item < PHASE_ITEMS; item++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    frame = frame + 1'b1;
                end else if (pick < 92 && pick >= 80) begin
                    frame = FRAME_W'($urandom());
                end else if (pick >= 92) begin
                    frame = ($urandom_range(0, 1) == 0) ? '0 : FRAME_MAX;
                end
                send_request(frame);
                if ($urandom_range(0, 59) == 0) begin
                    drain_requests();
                end
            end
        end

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (jitter_track.errors == 0 && jitter_track.pending_jitter.size() == 0) begin
            $display("halton_jitter_generator_core: match");
        end else begin
            $display("halton_jitter_generator_core: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/hjg_pkg.sv
rtl/core/hjg_datapath.sv
rtl/core/hjg_controller.sv
rtl/core/halton_jitter_generator_core.sv
test/testbench.sv
